/* rtl/core/rmvm_pkg.sv */
// Package for the running mean and variance merge core.
// Holds payload structs, state machine type, command/status structs and constants.
// No dependencies.
package rmvm_pkg;

  localparam int unsigned FEATURES_DEFAULT = 64;
  localparam int unsigned FEAT_W = 6;
  localparam int unsigned CNT_W = 40;
  localparam logic [CNT_W-1:0] COUNT_RESET = 40'd7;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic OP_MERGE = 1'b0;
  localparam logic OP_LOAD = 1'b1;
  localparam int unsigned DIV_STEPS = 64;

  typedef struct packed {
    logic               op;
    logic [FEAT_W-1:0]  feature;
    logic signed [31:0] value;
    logic [31:0]        spread;
    logic [15:0]        batch_size;
    logic               last_feature;
  } in_word_t;

  typedef struct packed {
    logic [FEAT_W-1:0]  out_feature;
    logic signed [31:0] new_mean;
    logic [31:0]        new_variance;
    logic               out_last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_READ, ST_PREP, ST_MUL, ST_DIV_START, ST_DIV_WAIT,
    ST_T3MUL, ST_FINISH, ST_OUT
  } state_t;

  // Divider job selects: which product feeds the divider.
  typedef enum logic [1:0] {
    JOB_STEPN, JOB_STEPC, JOB_T1, JOB_T2
  } job_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic read;
    logic prep;
    logic mul;
    job_t job;
    logic div_start;
    logic t3mul;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic is_load;
  } status_t;

endpackage

/* rtl/core/rmvm_div.sv */
// Iterative 80-by-40 bit restoring divider, one quotient bit per cycle.
// Saturates to all ones on overflow or zero divisor. Depends on rmvm_pkg.
module rmvm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [79:0] dividend,
  input  logic [39:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [39:0] rem;
  logic [63:0] lo;
  logic [63:0] q;
  logic [6:0]  cnt;
  logic        busy;
  logic        ovf;
  logic [40:0] shifted;
  logic [40:0] diff;

  assign shifted = {rem, lo[63]};
  assign diff = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        lo   <= dividend[63:0];
        rem  <= {24'd0, dividend[79:64]};
        q    <= '0;
        cnt  <= 7'd0;
        ovf  <= (divisor == 40'd0) || ({24'd0, dividend[79:64]} >= divisor);
      end else if (busy) begin
        lo <= {lo[62:0], 1'b0};
        if (!diff[40]) begin
          rem <= diff[39:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= shifted[39:0];
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(rmvm_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = ovf ? {64{1'b1}} : q;

endmodule

/* rtl/core/rmvm_datapath.sv */
// Datapath: moment memories, shared count, multiplier, divider and result register.
// Depends on rmvm_pkg and rmvm_div.
module rmvm_datapath #(
  parameter int unsigned FEATURES = rmvm_pkg::FEATURES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  rmvm_pkg::in_word_t  in_word,
  input  rmvm_pkg::cmd_t      cmd,
  output rmvm_pkg::status_t   status,
  output rmvm_pkg::out_word_t out_word
);

  localparam int unsigned AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  logic signed [31:0] mean_mem [FEATURES];
  logic [31:0]        var_mem  [FEATURES];
  logic [AW:0]        clr_idx;

  rmvm_pkg::in_word_t item;
  logic               valid_feat;
  logic [AW-1:0]      addr;
  logic signed [31:0] m;
  logic [31:0]        v;
  logic [rmvm_pkg::CNT_W-1:0] sample_count;
  logic [rmvm_pkg::CNT_W-1:0] c;
  logic [rmvm_pkg::CNT_W-1:0] t;
  logic [rmvm_pkg::CNT_W-1:0] n;
  logic               dneg;
  logic [32:0]        ad;
  logic [79:0]        prod;
  logic [63:0]        stepn, t1, t2;
  logic [31:0]        stepc;
  logic [63:0]        p3;
  logic [79:0]        div_a;
  logic [39:0]        div_b;
  logic               div_done;
  logic [63:0]        div_q;
  logic [40:0]        tsum;
  logic signed [33:0] nm;
  logic [33:0]        vsum;
  logic [31:0]        t3;
  logic signed [31:0] res_m;
  logic [31:0]        res_v;

  assign addr = AW'(item.feature);
  assign n = {8'd0, item.batch_size, 16'd0};
  assign tsum = {1'b0, c} + {1'b0, n};

  function automatic logic [31:0] cap32(input logic [63:0] x);
    cap32 = (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // Multiplier operand select; registered product feeds the divider.
  always_comb begin
    case (cmd.job)
      rmvm_pkg::JOB_STEPN: prod = {40'd0, 7'd0, ad} * {40'd0, n};
      rmvm_pkg::JOB_STEPC: prod = {40'd0, 7'd0, ad} * {40'd0, c};
      rmvm_pkg::JOB_T1:    prod = {48'd0, v} * {40'd0, c};
      default:             prod = {48'd0, item.spread} * {40'd0, n};
    endcase
  end

  assign div_b = t;

  rmvm_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  // Both step quotients are at most |d|, which is below 2^32, so a 32 by 32
  // product covers the cross term.
  assign t3 = cap32({16'd0, p3[63:16]});
  assign vsum = {2'b0, cap32(t1)} + {2'b0, cap32(t2)} + {2'b0, t3};

  always_comb begin
    if (dneg) nm = 34'(m) - $signed({1'b0, cap32(stepn)});
    else      nm = 34'(m) + $signed({1'b0, cap32(stepn)});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      sample_count <= rmvm_pkg::COUNT_RESET;
    end else begin
      if (cmd.clear_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.finish && item.op == rmvm_pkg::OP_MERGE && item.last_feature)
        sample_count <= t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mean_mem[clr_idx[AW-1:0]] <= '0;
      var_mem[clr_idx[AW-1:0]]  <= rmvm_pkg::ONE_Q16;
    end
    if (cmd.capture) begin
      item <= in_word;
      valid_feat <= {26'd0, in_word.feature} < 32'(FEATURES);
      c <= sample_count;
    end
    if (cmd.read) begin
      m <= mean_mem[addr];
      v <= var_mem[addr];
      t <= tsum[40] ? rmvm_pkg::COUNT_MAX : tsum[39:0];
    end
    if (cmd.prep) begin
      dneg <= (34'(item.value) - 34'(m)) < 0;
      ad <= ((34'(item.value) - 34'(m)) < 0) ? 33'(34'(m) - 34'(item.value))
                                             : 33'(34'(item.value) - 34'(m));
    end
    if (cmd.mul) div_a <= prod;
    if (div_done) begin
      case (cmd.job)
        rmvm_pkg::JOB_STEPN: stepn <= div_q;
        rmvm_pkg::JOB_STEPC: stepc <= div_q[31:0];
        rmvm_pkg::JOB_T1:    t1 <= div_q;
        default:             t2 <= div_q;
      endcase
    end
    if (cmd.t3mul) p3 <= stepc * stepn[31:0];
    if (cmd.finish) begin
      if (item.op == rmvm_pkg::OP_LOAD) begin
        res_m <= item.value;
        res_v <= item.spread;
      end else begin
        res_m <= (nm > 34'sh07FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (nm < -34'sh08000_0000) ? 32'sh8000_0000 : nm[31:0];
        res_v <= (vsum[33:32] != 2'd0) ? 32'hFFFF_FFFF : vsum[31:0];
      end
    end
    if (cmd.out_load) begin
      if (valid_feat) begin
        mean_mem[addr] <= res_m;
        var_mem[addr]  <= res_v;
      end
      out_word.out_feature  <= item.feature;
      out_word.new_mean     <= valid_feat ? res_m : '0;
      out_word.new_variance <= valid_feat ? res_v : '0;
      out_word.out_last     <= item.last_feature;
    end
  end

  assign status.clear_done = (clr_idx == (AW+1)'(FEATURES - 1)) && cmd.clear_step;
  assign status.div_done = div_done;
  assign status.is_load = item.op == rmvm_pkg::OP_LOAD;

endmodule

/* rtl/core/rmvm_ctrl.sv */
// Controller state machine: clearing pass, item sequencing over four divisions, handshakes.
// Depends on rmvm_pkg.
module rmvm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rmvm_pkg::status_t   status,
  output rmvm_pkg::cmd_t      cmd
);

  rmvm_pkg::state_t state, state_next;
  rmvm_pkg::job_t   job, job_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmvm_pkg::ST_CLEAR;
      job <= rmvm_pkg::JOB_STEPN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      job <= job_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    job_next = job;
    case (state)
      rmvm_pkg::ST_CLEAR: if (status.clear_done) state_next = rmvm_pkg::ST_IDLE;
      rmvm_pkg::ST_IDLE: if (in_valid) state_next = rmvm_pkg::ST_READ;
      rmvm_pkg::ST_READ: state_next = rmvm_pkg::ST_PREP;
      rmvm_pkg::ST_PREP: begin
        job_next = rmvm_pkg::JOB_STEPN;
        state_next = status.is_load ? rmvm_pkg::ST_FINISH : rmvm_pkg::ST_MUL;
      end
      rmvm_pkg::ST_MUL: state_next = rmvm_pkg::ST_DIV_START;
      rmvm_pkg::ST_DIV_START: state_next = rmvm_pkg::ST_DIV_WAIT;
      rmvm_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (job == rmvm_pkg::JOB_T2) state_next = rmvm_pkg::ST_T3MUL;
          else begin
            job_next = rmvm_pkg::job_t'(job + 2'd1);
            state_next = rmvm_pkg::ST_MUL;
          end
        end
      end
      rmvm_pkg::ST_T3MUL: state_next = rmvm_pkg::ST_FINISH;
      rmvm_pkg::ST_FINISH: state_next = rmvm_pkg::ST_OUT;
      rmvm_pkg::ST_OUT: if (!out_valid || !out_stall) state_next = rmvm_pkg::ST_IDLE;
      default: state_next = rmvm_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    cmd.job = job;
    in_stall = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      rmvm_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      rmvm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      rmvm_pkg::ST_READ: cmd.read = 1'b1;
      rmvm_pkg::ST_PREP: cmd.prep = 1'b1;
      rmvm_pkg::ST_MUL: cmd.mul = 1'b1;
      rmvm_pkg::ST_DIV_START: cmd.div_start = 1'b1;
      rmvm_pkg::ST_T3MUL: cmd.t3mul = 1'b1;
      rmvm_pkg::ST_FINISH: cmd.finish = 1'b1;
      rmvm_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result word dropped");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == rmvm_pkg::ST_IDLE) else $error("accept outside idle");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == rmvm_pkg::ST_DIV_WAIT) else $error("stray divider done");

endmodule

/* rtl/core/running_mean_variance_merge_core.sv */
// Top level of the running mean and variance merge core.
// Joins rmvm_ctrl and rmvm_datapath; uses rmvm_pkg types.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one word per item:
// a merge of one feature's batch moments by the parallel variance formula, or a
// load of initial moments. Each item yields exactly one output word on
// (out_valid, out_stall, out_data) with the feature's new mean and variance.
// All values are Q16.16; mean and variance saturate.
// Sequencing: a merge runs four 64-step divisions by the running total count,
// each preceded by a multiply, before its output word is loaded; a load skips
// them. The next item is taken once the current one has reached the output
// register. One item is in work at a time; the serial divider sets the rate.
// The output word sits in a register; the next item is accepted while it
// waits under stall, and the block then holds its next result until taken.
// Reset: a clearing pass writes mean zero and variance one to every feature;
// the count returns to its small start value. in_stall is high during the pass.
module running_mean_variance_merge_core #(
  parameter int unsigned FEATURES = rmvm_pkg::FEATURES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmvm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmvm_pkg::out_word_t out_data
);

  rmvm_pkg::cmd_t    cmd;
  rmvm_pkg::status_t status;

  rmvm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  rmvm_datapath #(.FEATURES(FEATURES)) u_dp (
    .clk(clk), .rst(rst), .in_word(in_data), .cmd(cmd), .status(status),
    .out_word(out_data)
  );

endmodule

/* bench/running_mean_variance_merge_core_tb.sv */
// Testbench for running_mean_variance_merge_core: per-feature mean and variance merge.
// Depends on rmvm_pkg and the core; drives words, predicts moments, checks each output word.
`timescale 1ns / 1ps
module running_mean_variance_merge_core_tb;

  localparam int NFEAT = 64;
  localparam int NRAND = 1700;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  rmvm_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  rmvm_pkg::out_word_t out_data;

  always #10 clk = ~clk;

  running_mean_variance_merge_core #(.FEATURES(NFEAT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // The predictor keeps its own copy of the moment tables and the shared count.
  logic signed [31:0] mean_mem [NFEAT];
  logic [31:0]        var_mem  [NFEAT];
  logic [39:0]        count_q;

  rmvm_pkg::out_word_t moments_due[$];
  int  mismatches = 0;
  int  words_sent = 0;
  int  words_seen = 0;
  int  merges_sent = 0;
  bit  input_done = 1'b0;

  // Wide product divided by the running total, truncated; all ones when it overflows.
  function automatic logic [63:0] scaled(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    logic [127:0] p;
    p = a * b;
    if (d == 0 || p[127:64] >= d) return '1;
    return p / d;
  endfunction

  function automatic logic [31:0] clip32(logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  // Applies one word to the predicted state and returns the output word it causes.
  function automatic rmvm_pkg::out_word_t fold_moments(rmvm_pkg::in_word_t w);
    rmvm_pkg::out_word_t r;
    logic [63:0] c, n, t, ad, stepn, stepc, t1, t2, t3, sum;
    logic [127:0] pr;
    longint m, d, nm;
    bit ok;
    ok = w.feature < NFEAT;
    c = count_q;
    n = {32'd0, w.batch_size, 16'd0};
    t = c + n;
    if (t > 64'hFF_FFFF_FFFF) t = 64'hFF_FFFF_FFFF;
    if (w.op == rmvm_pkg::OP_LOAD) begin
      if (ok) begin
        mean_mem[w.feature] = w.value;
        var_mem[w.feature] = w.spread;
      end
    end else begin
      if (ok) begin
        m = mean_mem[w.feature];
        d = longint'(w.value) - m;
        ad = (d < 0) ? -d : d;
        stepn = scaled(ad, n, t);
        stepc = scaled(ad, c, t);
        t1 = clip32(scaled(var_mem[w.feature], c, t));
        t2 = clip32(scaled(w.spread, n, t));
        pr = stepc * stepn;
        t3 = (pr[127:80] != 0) ? 64'hFFFF_FFFF : clip32(pr[79:16]);
        sum = clip32(t1 + t2 + t3);
        if (stepn > 64'hFFFF_FFFF) stepn = 64'hFFFF_FFFF;
        nm = (d < 0) ? m - longint'(stepn) : m + longint'(stepn);
        if (nm > 64'sd2147483647) nm = 64'sd2147483647;
        if (nm < -64'sd2147483648) nm = -64'sd2147483648;
        mean_mem[w.feature] = nm[31:0];
        var_mem[w.feature] = sum[31:0];
      end
      if (w.last_feature) count_q = t[39:0];
    end
    r.out_feature = w.feature;
    r.new_mean = ok ? mean_mem[w.feature] : '0;
    r.new_variance = ok ? var_mem[w.feature] : '0;
    r.out_last = w.last_feature;
    return r;
  endfunction

  // Sends one word after a random gap; e holds the predicted output word.
  task automatic send_word(rmvm_pkg::in_word_t w, bit typed, rmvm_pkg::out_word_t typed_exp);
    rmvm_pkg::out_word_t e;
    int gap;
    gap = $urandom_range(0, 14) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    e = fold_moments(w);
    if (typed && e !== typed_exp)
      $display("table row disagrees with predictor for feature %0d", w.feature);
    moments_due.push_back(typed ? typed_exp : e);
    in_data <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (w.op == rmvm_pkg::OP_MERGE) merges_sent++;
  endtask

  // Directed table. Rows marked typed carry a result that is read off directly.
  typedef struct {
    rmvm_pkg::in_word_t  w;
    bit                  typed;
    rmvm_pkg::out_word_t r;
  } row_t;

  function automatic rmvm_pkg::in_word_t mk(logic op, logic [5:0] f, logic [31:0] v,
                                            logic [31:0] s, logic [15:0] b, logic l);
    rmvm_pkg::in_word_t w;
    w.op = op; w.feature = f; w.value = v; w.spread = s;
    w.batch_size = b; w.last_feature = l;
    return w;
  endfunction

  function automatic rmvm_pkg::out_word_t ow(logic [5:0] f, logic [31:0] m, logic [31:0] v,
                                             logic l);
    rmvm_pkg::out_word_t r;
    r.out_feature = f; r.new_mean = m; r.new_variance = v; r.out_last = l;
    return r;
  endfunction

  row_t plan[$];

  initial begin
    rmvm_pkg::in_word_t w;
    for (int i = 0; i < NFEAT; i++) begin
      mean_mem[i] = '0;
      var_mem[i] = rmvm_pkg::ONE_Q16;
    end
    count_q = rmvm_pkg::COUNT_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Loads pass straight through, and a load marked last leaves the count alone.
    plan.push_back('{mk(rmvm_pkg::OP_LOAD, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1), 1,
                     ow(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1)});
    plan.push_back('{mk(rmvm_pkg::OP_LOAD, 63, 32'h8000_0000, 32'h0, 16'h0, 0), 1,
                     ow(63, 32'h8000_0000, 32'h0, 0)});
    plan.push_back('{mk(rmvm_pkg::OP_LOAD, 5, 32'h0001_0000, 32'h0002_0000, 16'd1, 1), 1,
                     ow(5, 32'h0001_0000, 32'h0002_0000, 1)});
    // A zero batch size adds nothing to a freshly reset feature.
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 7, 32'h1234_5678, 32'hFFFF_FFFF, 16'd0, 1), 1,
                     ow(7, 32'h0, rmvm_pkg::ONE_Q16, 1)});
    // Merges against the smallest count, at the extremes of mean and spread.
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0),
                     0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 0, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 0),
                     0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 63, 32'h7FFF_FFFF, 32'h0, 16'd1, 1), 0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 2, 32'h0003_0000, 32'h0, 16'd1, 0), 0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 2, 32'hFFFD_0000, 32'h0, 16'd1, 1), 0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 3, 32'h0000_8000, 32'h0001_0000, 16'd100, 1),
                     0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 0, 32'h8000_0000, 32'h0, 16'hFFFF, 1), 0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 63, 32'h0, 32'hAAAA_5555, 16'h5555, 0), 0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 42, 32'h5555_AAAA, 32'h5555_AAAA, 16'hAAAA, 1),
                     0, '0});
    plan.push_back('{mk(rmvm_pkg::OP_LOAD, 42, 32'hAAAA_5555, 32'h1, 16'h1, 0), 1,
                     ow(42, 32'hAAAA_5555, 32'h1, 0)});
    plan.push_back('{mk(rmvm_pkg::OP_MERGE, 42, 32'h7FFF_FFFF, 32'h0, 16'd2, 0), 0, '0});

    // The start lines are fed before the flag so every first row sees the reset state.
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].r);

    // Random part: mostly merges of varied batch sizes over a few features, some loads.
    for (int i = 0; i < NRAND; i++) begin
      w.op = ($urandom_range(0, 7) == 0) ? rmvm_pkg::OP_LOAD : rmvm_pkg::OP_MERGE;
      w.feature = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: w.value = $urandom;
        1: w.value = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom)};
        default: w.value = $signed(32'($urandom_range(0, 'h7_FFFF))) - 32'sh4_0000;
      endcase
      case ($urandom_range(0, 4))
        0: w.spread = $urandom;
        1: w.spread = '0;
        default: w.spread = $urandom_range(0, 'h8_0000);
      endcase
      case ($urandom_range(0, 5))
        0: w.batch_size = 16'($urandom);
        1: w.batch_size = '0;
        default: w.batch_size = 16'($urandom_range(1, 64));
      endcase
      w.last_feature = ($urandom_range(0, 3) == 0);
      send_word(w, 0, '0);
    end
    in_valid <= 1'b0;
    input_done = 1'b1;
  end

  // Output side: random stall per word, with stall-free stretches.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 14);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Each accepted output word is compared with the oldest predicted word.
  always @(posedge clk) begin
    rmvm_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (moments_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word for feature %0d",
                                       out_data.out_feature);
      end else begin
        e = moments_due.pop_front();
        if (out_data.out_feature !== e.out_feature || out_data.new_mean !== e.new_mean ||
            out_data.new_variance !== e.new_variance || out_data.out_last !== e.out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d: expected f=%0d m=%h v=%h l=%b, got f=%0d m=%h v=%h l=%b",
                     words_seen, e.out_feature, e.new_mean, e.new_variance, e.out_last,
                     out_data.out_feature, out_data.new_mean, out_data.new_variance,
                     out_data.out_last);
        end
      end
    end
  end

  // Ending: drain the queue, then allow one merge latency for strays.
  initial begin
    wait (input_done);
    while (moments_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (moments_due.size() != 0) mismatches++;
    $display("%0d words sent (%0d merges), %0d output words checked",
             words_sent, merges_sent, words_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest clean run.
  initial begin
    #60ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
